// ----- rtl/dq_pkg.sv -----
package dq_pkg;

    localparam int OPCODE_W       = 3;
    localparam int STATUS_W       = 3;
    localparam int POS_W          = 4;
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMDQ_DEPTH     = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_REM_HEAD = 3'd1,
        OP_REM_TAIL = 3'd2,
        OP_SEARCH   = 3'd3,
        OP_LIST_F   = 3'd4,
        OP_LIST_R   = 3'd5
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_MATCH    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_LISTED   = 3'd5
    } st_e_t;

endpackage

// ----- rtl/dq_ram.sv -----
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dq_front.sv -----
// Input stage: registers a word, drops unused opcodes, feeds the command queue.
module dq_front #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dq_pkg::OPCODE_W-1:0] opcode,
    input  logic [DATA_WIDTH-1:0]       value,
    input  logic                        q_full,
    output logic                        q_push,
    output dq_pkg::op_e_t               q_op,
    output logic [DATA_WIDTH-1:0]       q_value
);

    logic                  f_valid_reg, f_valid_next;
    dq_pkg::op_e_t         f_op_reg, f_op_next;
    logic [DATA_WIDTH-1:0] f_value_reg, f_value_next;
    logic                  dec_ok;
    dq_pkg::op_e_t         dec_op;
    logic                  load;

    always_comb
    begin
        dec_ok = 1'b0;
        dec_op = dq_pkg::OP_APPEND;
        unique case (opcode) inside
            dq_pkg::OP_APPEND, dq_pkg::OP_REM_HEAD, dq_pkg::OP_REM_TAIL,
            dq_pkg::OP_SEARCH, dq_pkg::OP_LIST_F, dq_pkg::OP_LIST_R:
            begin
                dec_ok = 1'b1;
                dec_op = dq_pkg::op_e_t'(opcode);
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    assign in_stall = f_valid_reg && q_full;
    assign q_push   = f_valid_reg && !q_full;
    assign load     = in_valid && !in_stall;
    assign q_op     = f_op_reg;
    assign q_value  = f_value_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_op_next    = f_op_reg;
        f_value_next = f_value_reg;
        if (load)
        begin
            f_valid_next = dec_ok;
            f_op_next    = dec_op;
            f_value_next = value;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_op_reg    <= f_op_next;
        f_value_reg <= f_value_next;
    end

endmodule

// ----- rtl/dq_cmdq.sv -----
// Short command FIFO between front and back.
module dq_cmdq #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dq_pkg::op_e_t         push_op,
    input  logic [DATA_WIDTH-1:0] push_value,
    output logic                  full,
    input  logic                  pop,
    output logic                  cmd_valid,
    output dq_pkg::op_e_t         cmd_op,
    output logic [DATA_WIDTH-1:0] cmd_value
);

    localparam int QAW = $clog2(dq_pkg::CMDQ_DEPTH);
    localparam int QCW = $clog2(dq_pkg::CMDQ_DEPTH + 1);

    dq_pkg::op_e_t         op_mem [dq_pkg::CMDQ_DEPTH];
    logic [DATA_WIDTH-1:0] val_mem [dq_pkg::CMDQ_DEPTH];
    logic [QAW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]        cnt_reg, cnt_next;
    logic                  do_pop;

    assign full      = (cnt_reg == QCW'(dq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_op    = op_mem[rd_ptr_reg];
    assign cmd_value = val_mem[rd_ptr_reg];
    assign do_pop    = pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= push_op;
            val_mem[wr_ptr_reg] <= push_value;
        end
    end

endmodule

// ----- rtl/dq_back.sv -----
// Executes commands against the ring store; one output register.
module dq_back #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  dq_pkg::op_e_t               cmd_op,
    input  logic [DATA_WIDTH-1:0]       cmd_value,
    output logic                        cmd_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dq_pkg::STATUS_W-1:0] status,
    output logic [dq_pkg::POS_W-1:0]    position,
    output logic [DATA_WIDTH-1:0]       element,
    output logic                        last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    dq_pkg::op_e_t         op_reg, op_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [AW-1:0]         pend_pos_reg, pend_pos_next;
    logic [DATA_WIDTH-1:0] pend_elt_reg, pend_elt_next;
    logic                  out_valid_reg, out_valid_next;
    dq_pkg::st_e_t         out_st_reg, out_st_next;
    logic [AW-1:0]         out_pos_reg, out_pos_next;
    logic [DATA_WIDTH-1:0] out_elt_reg, out_elt_next;
    logic                  out_last_reg, out_last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  out_free;
    logic                  is_empty;
    logic                  is_full;
    logic [CW-1:0]         count_m1;
    logic                  at_end;
    logic                  hit;

    // ring slot of a position counted from the head
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        begin
            sum = {1'b0, head} + {1'b0, pos};
            if (sum >= (AW+1)'(DEPTH))
            begin
                sum = sum - (AW+1)'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign count_m1  = count_reg - CW'(1);
    assign hit       = (ram_rdata == key_reg);
    // read port follows the next pointer so its registered data matches ptr_reg
    assign ram_raddr = slot_of(head_reg, ptr_next);
    assign ram_waddr = slot_of(head_reg, AW'(count_reg));

    always_comb
    begin
        if (op_reg == dq_pkg::OP_LIST_R)
        begin
            at_end = (ptr_reg == '0);
        end
        else
        begin
            at_end = (CW'(ptr_reg) == count_m1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ptr_next        = ptr_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_elt_next   = pend_elt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_st_next     = out_st_reg;
        out_pos_next    = out_pos_reg;
        out_elt_next    = out_elt_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop       = 1'b1;
                    op_next       = cmd_op;
                    key_next      = cmd_value;
                    out_pos_next  = '0;
                    out_elt_next  = '0;
                    out_last_next = 1'b1;
                    unique case (cmd_op) inside
                        dq_pkg::OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_st_next = dq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                out_st_next = dq_pkg::ST_OK;
                            end
                        end
                        dq_pkg::OP_REM_HEAD, dq_pkg::OP_REM_TAIL,
                        dq_pkg::OP_LIST_F, dq_pkg::OP_LIST_R:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                out_st_next    = dq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                                if (cmd_op == dq_pkg::OP_REM_TAIL ||
                                    cmd_op == dq_pkg::OP_LIST_R)
                                begin
                                    ptr_next = AW'(count_m1);
                                end
                                else
                                begin
                                    ptr_next = '0;
                                end
                            end
                        end
                        dq_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                out_st_next    = dq_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next      = S_WALK;
                                ptr_next        = '0;
                                pend_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                unique case (op_reg) inside
                    dq_pkg::OP_REM_HEAD, dq_pkg::OP_REM_TAIL:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_st_next    = dq_pkg::ST_OK;
                            out_pos_next   = '0;
                            out_elt_next   = ram_rdata;
                            out_last_next  = 1'b1;
                            count_next     = count_m1;
                            if (op_reg == dq_pkg::OP_REM_HEAD)
                            begin
                                head_next = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    dq_pkg::OP_LIST_F, dq_pkg::OP_LIST_R:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_st_next    = dq_pkg::ST_LISTED;
                            out_pos_next   = ptr_reg;
                            out_elt_next   = ram_rdata;
                            out_last_next  = at_end;
                            if (at_end)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (op_reg == dq_pkg::OP_LIST_F)
                            begin
                                ptr_next = ptr_reg + 1'b1;
                            end
                            else
                            begin
                                ptr_next = ptr_reg - 1'b1;
                            end
                        end
                    end
                    dq_pkg::OP_SEARCH:
                    begin
                        // a match is held back until the next one shows whether it is final
                        if (!(hit && pend_valid_reg && !out_free))
                        begin
                            if (hit)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_st_next    = dq_pkg::ST_MATCH;
                                    out_pos_next   = pend_pos_reg;
                                    out_elt_next   = pend_elt_reg;
                                    out_last_next  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_pos_next   = ptr_reg;
                                pend_elt_next   = ram_rdata;
                            end
                            if (at_end)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        out_st_next  = dq_pkg::ST_MATCH;
                        out_pos_next = pend_pos_reg;
                        out_elt_next = pend_elt_reg;
                    end
                    else
                    begin
                        out_st_next  = dq_pkg::ST_NOTFOUND;
                        out_pos_next = '0;
                        out_elt_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= dq_pkg::OP_APPEND;
            ptr_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            key_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_pos_reg   <= '0;
            pend_elt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_st_reg     <= dq_pkg::ST_OK;
            out_pos_reg    <= '0;
            out_elt_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            ptr_reg        <= ptr_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            key_reg        <= key_next;
            pend_valid_reg <= pend_valid_next;
            pend_pos_reg   <= pend_pos_next;
            pend_elt_reg   <= pend_elt_next;
            out_valid_reg  <= out_valid_next;
            out_st_reg     <= out_st_next;
            out_pos_reg    <= out_pos_next;
            out_elt_reg    <= out_elt_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign position  = dq_pkg::POS_W'(out_pos_reg);
    assign element   = out_elt_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/deque_with_linear_search_top.sv -----
// Double-ended queue of DEPTH signed words held in a ring buffer, with linear
// search. Each input word carries one command: append at the tail, remove the
// head, remove the tail, search for a key, or list all entries front-to-back or
// back-to-front. Append and remove give one result word; search gives one
// word per matching position (or a single not-found word), list gives one
// word per stored entry (or a single empty word); the final word of every
// command has last set. Opcodes 6 and 7 are dropped with no result.
// A command passes through the input register and the command queue to the
// execution unit. Append and any command on an empty store are answered
// straight from the idle state; remove reads one entry, list walks every
// stored entry, and search walks every stored entry and then a finish step.
// The walk is paced by the single read port of the store, one entry per
// cycle unless out_stall holds it. Input and execution are decoupled by a
// two-entry command queue, and output back-pressure (out_stall) simply
// pauses the walk.
module deque_with_linear_search_top #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // command words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dq_pkg::OPCODE_W-1:0]   opcode,
    input  logic signed [DATA_WIDTH-1:0]  value,

    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dq_pkg::STATUS_W-1:0]   status,
    output logic [dq_pkg::POS_W-1:0]      position,
    output logic signed [DATA_WIDTH-1:0]  element,
    output logic                          last
);

    // front to queue
    logic                  q_push;
    dq_pkg::op_e_t         q_op;
    logic [DATA_WIDTH-1:0] q_value;
    logic                  q_full;

    // queue to back
    logic                  cmd_valid;
    dq_pkg::op_e_t         cmd_op;
    logic [DATA_WIDTH-1:0] cmd_value;
    logic                  cmd_pop;

    logic [DATA_WIDTH-1:0] element_raw;

    // Front: registers the command word and discards unused opcodes.
    dq_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_op),
        .q_value  (q_value)
    );

    // Two-entry queue lets the front keep taking words while a walk runs.
    dq_cmdq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_op),
        .push_value (q_value),
        .full       (q_full),
        .pop        (cmd_pop),
        .cmd_valid  (cmd_valid),
        .cmd_op     (cmd_op),
        .cmd_value  (cmd_value)
    );

    // Back: owns the ring store, head/count and the output register.
    dq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_op),
        .cmd_value (cmd_value),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position),
        .element   (element_raw),
        .last      (last)
    );

    assign element = element_raw;

endmodule
